### sv/msp_pkg.sv
package msp_pkg;

    // Fixed-point constants of the regulator
    localparam int unsigned FILTER_MS   = 20;
    localparam int unsigned TIMER_HZ    = 128834;
    localparam int unsigned SPD_SCALE   = 100000;
    localparam int unsigned SPD_SAT     = 40000;
    localparam int unsigned PWM_MAX     = 10000;
    localparam int unsigned KI_DIV      = 1000;
    localparam int unsigned KI_X100     = 8;
    localparam int unsigned MAX_INT_MS  = 50;
    localparam int unsigned STOP_BAND   = 100;

    // x / KI_DIV as (x * KI_RECIP) >> KI_SHIFT, exact for x below 2^25
    localparam int unsigned KI_RECIP    = 34359739;
    localparam int unsigned KI_SHIFT    = 35;

    // Shared divider geometry
    localparam int unsigned NUM_W = 66;
    localparam int unsigned DEN_W = 49;
    localparam int unsigned QUO_W = 18;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_RESET_STATE,
        CMD_MUL1,
        CMD_MUL2,
        CMD_FILT,
        CMD_PI,
        CMD_KI,
        CMD_FINISH,
        CMD_ZERO_OUT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        logic    div_start;
    } ctrl_cmd_t;

    typedef struct packed {
        logic mode;
        logic elapsed_zero;
        logic div_done;
        logic out_free;
    } dp_sts_t;

endpackage

### sv/msp_if.sv
interface msp_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [31:0] encoder_count;
    logic        [31:0] time_ms;
    logic signed [7:0]  speed_setpoint;
    logic signed [14:0] applied_pwm;
    logic        [13:0] pwm_limit;

    modport source (output valid, mode, encoder_count, time_ms, speed_setpoint,
                    applied_pwm, pwm_limit, input ready);
    modport sink (input valid, mode, encoder_count, time_ms, speed_setpoint,
                  applied_pwm, pwm_limit, output ready);
endinterface

interface msp_out_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] pwm_out;

    modport source (output valid, pwm_out, input ready);
    modport sink (input valid, pwm_out, output ready);
endinterface

### sv/msp_div.sv
module msp_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [msp_pkg::NUM_W-1:0]     num,
    input  logic [msp_pkg::DEN_W-1:0]     den,
    output logic                          done,
    output logic [msp_pkg::QUO_W-1:0]     quo,
    output logic                          ovf
);

    localparam int unsigned CNT_W = $clog2(msp_pkg::QUO_W);
    localparam int unsigned DSH_W = msp_pkg::DEN_W + msp_pkg::QUO_W - 1;

    logic                      busy_reg;
    logic                      done_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [msp_pkg::NUM_W-1:0] rem_reg;
    logic [DSH_W-1:0]          dsh_reg;
    logic [msp_pkg::QUO_W-1:0] quo_reg;
    logic                      ovf_reg;
    logic                      ge;

    // restoring division, one quotient bit per cycle
    assign ge = (rem_reg >= dsh_reg);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(msp_pkg::QUO_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (start)
        begin
            rem_reg <= num;
            dsh_reg <= {den, {(msp_pkg::QUO_W - 1){1'b0}}};
            quo_reg <= '0;
            ovf_reg <= ({1'b0, num} >= {den, {msp_pkg::QUO_W{1'b0}}});
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - msp_pkg::NUM_W'(dsh_reg);
            end
            quo_reg <= {quo_reg[msp_pkg::QUO_W-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign ovf  = ovf_reg;

endmodule

### sv/msp_dp.sv
module msp_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    msp_in_if.sink              in_ch,
    msp_out_if.source           out_ch,
    input  msp_pkg::ctrl_cmd_t  cmd,
    output msp_pkg::dp_sts_t    sts
);

    // architectural state
    logic        [15:0] cps_reg;
    logic        [31:0] last_cnt_reg;
    logic        [31:0] last_time_reg;
    logic signed [16:0] fs_reg;
    logic signed [17:0] perr_reg;

    // per-request working registers
    logic                mode_reg;
    logic        [31:0]  cnt_in_reg;
    logic        [31:0]  now_reg;
    logic signed [7:0]   tgt_reg;
    logic signed [14:0]  app_reg;
    logic        [13:0]  lim_reg;
    logic        [31:0]  elapsed_reg;
    logic                neg_reg;
    logic [msp_pkg::NUM_W-1:0] num_reg;
    logic [msp_pkg::DEN_W-1:0] den_reg;
    logic signed [17:0]  err_reg;
    logic signed [20:0]  kp_reg;
    logic        [15:0]  kiq_reg;

    logic                out_valid_reg;
    logic signed [14:0]  pwm_reg;

    logic                      div_done;
    logic [msp_pkg::QUO_W-1:0] div_quo;
    logic                      div_ovf;

    msp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_reg),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo),
        .ovf   (div_ovf)
    );

    // combinational helpers
    logic signed [32:0] dcount;
    logic        [32:0] dmag_cnt;
    logic        [16:0] smag;
    logic signed [16:0] sample;
    logic signed [17:0] diff;
    logic        [16:0] dmag;
    logic signed [16:0] fs_new;
    logic signed [17:0] err_new;
    logic signed [18:0] derr;
    logic signed [21:0] kp_x;
    logic        [16:0] emag;
    logic        [5:0]  integ;
    logic        [50:0] kprod;
    logic signed [16:0] ki;
    logic signed [22:0] req;
    logic signed [22:0] lo;
    logic signed [22:0] hi;
    logic signed [22:0] lim_s;
    logic signed [14:0] res;
    logic signed [14:0] zres;
    logic               stop;
    logic               out_free;

    always_comb begin
        dcount   = $signed({cnt_in_reg[31], cnt_in_reg})
                 - $signed({last_cnt_reg[31], last_cnt_reg});
        dmag_cnt = dcount[32] ? 33'(-dcount) : 33'(dcount);

        smag   = (div_ovf || (div_quo > msp_pkg::QUO_W'(msp_pkg::SPD_SAT)))
               ? 17'(msp_pkg::SPD_SAT) : div_quo[16:0];
        sample = neg_reg ? -$signed(smag) : $signed(smag);
        diff   = 18'(sample) - 18'(fs_reg);
        dmag   = diff[17] ? 17'(-diff) : 17'(diff);

        fs_new  = neg_reg ? fs_reg - $signed(div_quo[16:0])
                          : fs_reg + $signed(div_quo[16:0]);
        err_new = 18'(tgt_reg) * 18'sd100 - 18'(fs_new);
        derr    = 19'(err_new) - 19'(perr_reg);
        kp_x    = 22'(derr) * 22'sd5;
        emag    = err_new[17] ? 17'(-err_new) : 17'(err_new);
        integ   = (elapsed_reg > 32'(msp_pkg::MAX_INT_MS))
                ? 6'(msp_pkg::MAX_INT_MS) : elapsed_reg[5:0];

        // integral term divided by KI_DIV through a reciprocal multiply
        kprod = 51'(num_reg[24:0]) * 51'(msp_pkg::KI_RECIP);

        ki    = neg_reg ? -$signed({1'b0, kiq_reg}) : $signed({1'b0, kiq_reg});
        req   = 23'(app_reg) + 23'(kp_reg) + 23'(ki);
        lim_s = $signed({9'b0, lim_reg});
        lo    = (tgt_reg > 8'sd0) ? 23'sd0 : -lim_s;
        hi    = (tgt_reg < 8'sd0) ? 23'sd0 : lim_s;
        stop  = (tgt_reg == 8'sd0) && (fs_reg > -17'sd100) && (fs_reg < 17'sd100);
        if (stop)
            res = '0;
        else if (req < lo)
            res = 15'(lo);
        else if (req > hi)
            res = 15'(hi);
        else
            res = 15'(req);

        if (23'(app_reg) < -lim_s)
            zres = 15'(-lim_s);
        else if (23'(app_reg) > lim_s)
            zres = 15'(lim_s);
        else
            zres = app_reg;

        out_free = !out_valid_reg || out_ch.ready;
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            cps_reg       <= 16'd1;
            last_cnt_reg  <= '0;
            last_time_reg <= '0;
            fs_reg        <= '0;
            perr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cps_reg <= cfg_wdata;
            if (out_ch.ready)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                msp_pkg::CMD_RESET_STATE:
                begin
                    last_cnt_reg  <= cnt_in_reg;
                    last_time_reg <= now_reg;
                    fs_reg        <= '0;
                    perr_reg      <= '0;
                end
                msp_pkg::CMD_PI:
                begin
                    fs_reg <= fs_new;
                end
                msp_pkg::CMD_FINISH:
                begin
                    last_cnt_reg  <= cnt_in_reg;
                    last_time_reg <= now_reg;
                    perr_reg      <= err_reg;
                    out_valid_reg <= 1'b1;
                end
                msp_pkg::CMD_ZERO_OUT:
                begin
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload
    always_ff @(posedge clk) begin
        case (cmd.op)
            msp_pkg::CMD_LOAD:
            begin
                mode_reg    <= in_ch.mode;
                cnt_in_reg  <= in_ch.encoder_count;
                now_reg     <= in_ch.time_ms;
                tgt_reg     <= in_ch.speed_setpoint;
                app_reg     <= in_ch.applied_pwm;
                lim_reg     <= (in_ch.pwm_limit > 14'(msp_pkg::PWM_MAX))
                             ? 14'(msp_pkg::PWM_MAX) : in_ch.pwm_limit;
                elapsed_reg <= in_ch.time_ms - last_time_reg;
            end
            msp_pkg::CMD_MUL1:
            begin
                neg_reg <= dcount[32];
                num_reg <= msp_pkg::NUM_W'(dmag_cnt * cps_reg);
                den_reg <= msp_pkg::DEN_W'(elapsed_reg * 17'(msp_pkg::TIMER_HZ));
            end
            msp_pkg::CMD_MUL2:
            begin
                num_reg <= msp_pkg::NUM_W'(num_reg[48:0] * 17'(msp_pkg::SPD_SCALE));
            end
            msp_pkg::CMD_FILT:
            begin
                neg_reg <= diff[17];
                num_reg <= msp_pkg::NUM_W'(dmag * elapsed_reg);
                den_reg <= msp_pkg::DEN_W'({1'b0, elapsed_reg} + 33'(msp_pkg::FILTER_MS));
            end
            msp_pkg::CMD_PI:
            begin
                err_reg <= err_new;
                kp_reg  <= 21'((kp_x + 22'(kp_x[21])) >>> 1);
                neg_reg <= err_new[17];
                num_reg <= msp_pkg::NUM_W'(emag * integ * 4'(msp_pkg::KI_X100));
            end
            msp_pkg::CMD_KI:
            begin
                kiq_reg <= 16'(kprod >> msp_pkg::KI_SHIFT);
            end
            msp_pkg::CMD_FINISH:
            begin
                pwm_reg <= res;
            end
            msp_pkg::CMD_ZERO_OUT:
            begin
                pwm_reg <= zres;
            end
            default:
            begin
            end
        endcase
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.pwm_out = pwm_reg;

    assign sts.mode         = mode_reg;
    assign sts.elapsed_zero = (elapsed_reg == '0);
    assign sts.div_done     = div_done;
    assign sts.out_free     = out_free;

endmodule

### sv/msp_ctrl.sv
module msp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  msp_pkg::dp_sts_t    sts,
    output msp_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL2,
        ST_SPD_GO,
        ST_SPD_WAIT,
        ST_FILT_PREP,
        ST_FILT_GO,
        ST_FILT_WAIT,
        ST_PI_PREP,
        ST_KI,
        ST_FINISH,
        ST_ZOUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next    = state_reg;
        cmd.op        = msp_pkg::CMD_NONE;
        cmd.div_start = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = msp_pkg::CMD_LOAD;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (sts.mode)
                begin
                    cmd.op     = msp_pkg::CMD_RESET_STATE;
                    state_next = ST_IDLE;
                end
                else if (sts.elapsed_zero)
                begin
                    state_next = ST_ZOUT;
                end
                else
                begin
                    cmd.op     = msp_pkg::CMD_MUL1;
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                cmd.op     = msp_pkg::CMD_MUL2;
                state_next = ST_SPD_GO;
            end
            ST_SPD_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_SPD_WAIT;
            end
            ST_SPD_WAIT:
            begin
                if (sts.div_done)
                    state_next = ST_FILT_PREP;
            end
            ST_FILT_PREP:
            begin
                cmd.op     = msp_pkg::CMD_FILT;
                state_next = ST_FILT_GO;
            end
            ST_FILT_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_FILT_WAIT;
            end
            ST_FILT_WAIT:
            begin
                if (sts.div_done)
                    state_next = ST_PI_PREP;
            end
            ST_PI_PREP:
            begin
                cmd.op     = msp_pkg::CMD_PI;
                state_next = ST_KI;
            end
            ST_KI:
            begin
                cmd.op     = msp_pkg::CMD_KI;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = msp_pkg::CMD_FINISH;
                    state_next = ST_IDLE;
                end
            end
            ST_ZOUT:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = msp_pkg::CMD_ZERO_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == ST_IDLE);

    a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_DECIDE))
        else $error("accepted request did not move to decode");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> (state_reg == ST_SPD_WAIT || state_reg == ST_FILT_WAIT))
        else $error("divider finished outside a wait state");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == msp_pkg::CMD_FINISH || cmd.op == msp_pkg::CMD_ZERO_OUT)
        |-> sts.out_free)
        else $error("result written into a full output register");

    a_start_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> (state_reg == ST_SPD_WAIT || state_reg == ST_FILT_WAIT))
        else $error("divider started without a wait state following");

endmodule

### sv/motor_speed_pi_regulator_unit.sv
// Incremental PI motor speed regulator. Each request is either a state reset
// (mode = 1, no result) or a control step producing one pwm_out. A control
// step shows its result once the output register is free: the speed sample
// and the first-order filter each run on one shared restoring divider (18
// quotient bits, one per cycle), the integral term is scaled by a reciprocal
// multiply, and the rest is setup and the output write. The next request is
// accepted in the cycle after the output write. A step with zero elapsed time
// skips both divisions and goes straight to the output write; a reset request
// frees the input once it has been decoded. One request is in flight at a
// time; the result sits in an output register, so a new request is taken
// while it waits for the sink. The user writes counts_per_speed_unit through
// cfg_we/cfg_wdata only while idle; the block itself does not enforce it.
module motor_speed_pi_regulator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    msp_in_if.sink      in_ch,
    msp_out_if.source   out_ch
);

    msp_pkg::ctrl_cmd_t cmd;
    msp_pkg::dp_sts_t   sts;
    logic               ready;

    // sequencer: walks multiply, divide and update steps
    msp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    assign in_ch.ready = ready;

    // datapath: regulator state, arithmetic and output register
    msp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

### tb/sv/msp_tb_if.sv
`timescale 1ns / 1ps

// Channel interfaces are supplied with the RTL (sv/msp_if.sv); this file only
// carries the request record used by the testbench.
package msp_tb_pkg;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] encoder_count;
        logic        [31:0] time_ms;
        logic signed [7:0]  speed_setpoint;
        logic signed [14:0] applied_pwm;
        logic        [13:0] pwm_limit;
    } speed_req_t;

endpackage

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the incremental PI speed regulator.
// Requests are queued by the stimulus block, driven by a clocked driver with
// random idle bursts, and every pwm_out is checked against an in-bench model.
module tb_top;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    msp_in_if  in_ch ();
    msp_out_if out_ch ();

    motor_speed_pi_regulator_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source)
    );

    // Regulator state as the model sees it
    logic [15:0]        m_cps;
    logic [31:0]        m_last_count;
    logic [31:0]        m_last_time;
    longint             m_filt;
    longint             m_prev_err;

    msp_tb_pkg::speed_req_t req_queue[$];
    logic signed [14:0] pwm_expected[$];
    int                 fail_cnt;
    bit                 quiet;       // no idling at the end of the run
    bit                 hold_sink;   // long receiver hold-off
    int                 sink_idle;
    int                 src_idle;
    bit                 stim_done;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Generous run limit
    initial
    begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Speed sample from the count change, to 1/100 percent, saturated.
    function automatic longint speed_of(longint dcount, longint cps, longint dt);
        longint mag;
        longint den;
        longint num;
        longint q;
        longint r;
        mag = dcount < 0 ? -dcount : dcount;
        den = dt * 128834;
        num = mag * cps * 100;
        q = num / den;
        r = num % den;
        if (q > 40000)
            q = 40000;
        else
        begin
            q = q * 1000 + (r * 1000) / den;
            if (q > 40000)
                q = 40000;
        end
        return dcount < 0 ? -q : q;
    endfunction

    // Applies one request to the model; returns 1 when a pwm_out is due.
    function automatic bit regulate(msp_tb_pkg::speed_req_t rq,
                                    output logic signed [14:0] pwm);
        longint lim;
        longint dt;
        longint smp;
        longint err;
        longint want;
        longint lo;
        longint hi;
        longint tgt;
        longint dc;
        logic [31:0] el;
        pwm = '0;
        if (rq.mode)
        begin
            m_last_count = rq.encoder_count;
            m_last_time  = rq.time_ms;
            m_filt       = 0;
            m_prev_err   = 0;
            return 1'b0;
        end
        lim = rq.pwm_limit > 10000 ? 10000 : longint'(rq.pwm_limit);
        el  = rq.time_ms - m_last_time;
        dt  = longint'(el);
        if (el == 0)
        begin
            pwm = 15'(clamp(longint'(rq.applied_pwm), -lim, lim));
            return 1'b1;
        end
        dc  = longint'(rq.encoder_count) - longint'($signed(m_last_count));
        smp = speed_of(dc, longint'(m_cps), dt);
        m_last_count = rq.encoder_count;
        m_last_time  = rq.time_ms;
        m_filt += ((smp - m_filt) * dt) / (20 + dt);
        tgt  = longint'(rq.speed_setpoint);
        err  = tgt * 100 - m_filt;
        want = longint'(rq.applied_pwm) + ((err - m_prev_err) * 250) / 100
             + (err * 8 * (dt > 50 ? 50 : dt)) / 1000;
        m_prev_err = err;
        lo = tgt > 0 ? 0 : -lim;
        hi = tgt < 0 ? 0 : lim;
        if (tgt == 0 && m_filt > -100 && m_filt < 100)
            pwm = '0;
        else
            pwm = 15'(clamp(want, lo, hi));
        return 1'b1;
    endfunction

    // Driver: pops the request queue, idles in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.mode <= 1'b0;
            in_ch.encoder_count <= '0;
            in_ch.time_ms <= '0;
            in_ch.speed_setpoint <= '0;
            in_ch.applied_pwm <= '0;
            in_ch.pwm_limit <= '0;
            src_idle <= 0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            logic signed [14:0] p;
            msp_tb_pkg::speed_req_t rq;
            // the request just taken is predicted here
            if (in_ch.valid)
            begin
                rq = {in_ch.mode, in_ch.encoder_count, in_ch.time_ms,
                      in_ch.speed_setpoint, in_ch.applied_pwm, in_ch.pwm_limit};
                if (regulate(rq, p))
                    pwm_expected.push_back(p);
            end
            if (src_idle > 0)
            begin
                src_idle <= src_idle - 1;
                in_ch.valid <= 1'b0;
            end
            else if (req_queue.size() > 0)
            begin
                rq = req_queue.pop_front();
                {in_ch.mode, in_ch.encoder_count, in_ch.time_ms, in_ch.speed_setpoint,
                 in_ch.applied_pwm, in_ch.pwm_limit} <= rq;
                in_ch.valid <= 1'b1;
                if (!quiet && $urandom_range(0, 7) == 0)
                    src_idle <= $urandom_range(1, 15);
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Monitor: checks each pwm_out against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            sink_idle <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pwm_expected.size() == 0)
                begin
                    $error("pwm_out: unexpected result %0d", out_ch.pwm_out);
                    fail_cnt <= fail_cnt + 1;
                end
                else if (out_ch.pwm_out !== pwm_expected[0])
                begin
                    $error("pwm_out: expected %0d actual %0d", pwm_expected[0],
                           out_ch.pwm_out);
                    fail_cnt <= fail_cnt + 1;
                    void'(pwm_expected.pop_front());
                end
                else
                    void'(pwm_expected.pop_front());
            end
            if (hold_sink)
                out_ch.ready <= 1'b0;
            else if (sink_idle > 0)
            begin
                sink_idle <= sink_idle - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0)
                    sink_idle <= $urandom_range(1, 15);
            end
        end
    end

    // Queued time keeps advancing so elapsed stays sane
    logic [31:0] now_ms;

    function automatic msp_tb_pkg::speed_req_t make_req(bit md, logic [31:0] cnt,
                                                        logic [31:0] t,
                                                        logic [7:0] tg,
                                                        logic [14:0] ap,
                                                        logic [13:0] lm);
        msp_tb_pkg::speed_req_t rq;
        rq = {md, cnt, t, tg, ap, lm};
        return rq;
    endfunction

    function automatic msp_tb_pkg::speed_req_t rand_req();
        msp_tb_pkg::speed_req_t rq;
        int unsigned pick;
        logic [31:0] dt;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            dt = 0;
        else if (pick < 80)
            dt = $urandom_range(1, 120);
        else if (pick < 95)
            dt = $urandom_range(1, 5000);
        else
            dt = $urandom();
        now_ms = now_ms + dt;
        rq.mode = ($urandom_range(0, 19) == 0);
        rq.time_ms = now_ms;
        if ($urandom_range(0, 9) == 0)
            rq.encoder_count = $urandom();
        else
            rq.encoder_count = $signed(now_ms) * $signed($urandom_range(0, 40))
                             + $signed($urandom_range(0, 2000)) - 1000;
        rq.speed_setpoint = 8'($urandom());
        if ($urandom_range(0, 5) == 0)
            rq.speed_setpoint = 0;
        rq.applied_pwm = 15'($signed($urandom_range(0, 20000)) - 10000);
        rq.pwm_limit = ($urandom_range(0, 5) == 0) ? 14'($urandom())
                                                    : 14'($urandom_range(0, 10000));
        return rq;
    endfunction

    task automatic drain();
        int n;
        n = 0;
        while ((req_queue.size() > 0 || in_ch.valid || pwm_expected.size() > 0)
               && n < 200000)
        begin
            @(posedge clk);
            n++;
        end
        // a reset request may still be finishing
        repeat (100) @(posedge clk);
    endtask

    task automatic write_cps(logic [15:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        m_cps = v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [15:0] cps_set[5];
        int hold_n;
        cps_set = '{16'd0, 16'd65535, 16'd1, 16'd4, 16'd300};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        quiet = 1'b0;
        hold_sink = 1'b0;
        stim_done = 1'b0;
        fail_cnt = 0;
        m_cps = 16'd1;
        m_last_count = '0;
        m_last_time = '0;
        m_filt = 0;
        m_prev_err = 0;
        now_ms = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: reset default scale, extremes, zero elapsed, windows
        req_queue.push_back(make_req(0, 0, 0, 8'sd50, 15'sd10000, 14'd16383));
        req_queue.push_back(make_req(0, 1000, 10, 8'sd127, -15'sd10000, 14'd10000));
        req_queue.push_back(make_req(0, -32'sd2147483648, 11, -8'sd128, 15'sd10000,
                                     14'd10000));
        req_queue.push_back(make_req(0, 32'sd2147483647, 12, -8'sd128, -15'sd10000,
                                     14'd0));
        req_queue.push_back(make_req(0, 32'sd2147483647, 12, 8'sd0, -15'sd10000,
                                     14'd9000));
        req_queue.push_back(make_req(1, 500, 32'hFFFF_FFF0, 8'sd0, 0, 14'd10000));
        req_queue.push_back(make_req(0, 500, 32'hFFFF_FFF8, 8'sd0, 15'sd300,
                                     14'd10000));
        req_queue.push_back(make_req(0, 800, 32'd20, 8'sd0, -15'sd300, 14'd10000));
        req_queue.push_back(make_req(0, 800, 32'd200, 8'sd60, 15'sd16383, 14'd16383));
        req_queue.push_back(make_req(0, -3000, 32'd201, -8'sd60, 15'sd0, 14'd5000));
        req_queue.push_back(make_req(0, -3000, 32'hFFFF_0000, 8'sd1, 15'sd1, 14'd1));
        req_queue.push_back(make_req(1, 0, 0, 0, 0, 0));
        now_ms = 0;
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            write_cps(cps_set[ph]);
            for (int i = 0; i < 180; i++)
                req_queue.push_back(rand_req());
            if (ph == 2)
            begin
                // receiver holds off while requests keep coming
                hold_sink = 1'b1;
                hold_n = 0;
                while (hold_n < 600)
                begin
                    @(posedge clk);
                    hold_n++;
                end
                hold_sink = 1'b0;
            end
            if (ph == 4)
                quiet = 1'b1;
            drain();
        end
        stim_done = 1'b1;
    end

    // Final verdict
    initial
    begin
        wait (stim_done);
        @(posedge clk);
        if (fail_cnt == 0 && pwm_expected.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
